/* rtl/ps2kc_pkg.sv */
// Shared types and codes for the ps/2 keyboard controller port block.
// Used by ps2kc_core and ps2_keyboard_controller_ports; no dependencies.
package ps2kc_pkg;

  // low i/o addresses
  localparam logic [7:0] PORT_DATA = 8'h60;
  localparam logic [7:0] PORT_B    = 8'h61;
  localparam logic [7:0] PORT_CMD  = 8'h64;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // keyboard commands written to the data port
  localparam logic [7:0] KC_SET_LED  = 8'hed;
  localparam logic [7:0] KC_ECHO     = 8'hee;
  localparam logic [7:0] KC_SCAN_SET = 8'hf0;
  localparam logic [7:0] KC_READ_ID  = 8'hf2;
  localparam logic [7:0] KC_RATE     = 8'hf3;
  localparam logic [7:0] KC_ENABLE   = 8'hf4;
  localparam logic [7:0] KC_DIS_DEF  = 8'hf5;
  localparam logic [7:0] KC_DEFAULT  = 8'hf6;
  localparam logic [7:0] KC_ALL_LO   = 8'hf7;
  localparam logic [7:0] KC_ALL_HI   = 8'hfa;
  localparam logic [7:0] KC_KEY_LO   = 8'hfb;
  localparam logic [7:0] KC_KEY_HI   = 8'hfd;
  localparam logic [7:0] KC_RESEND   = 8'hfe;
  localparam logic [7:0] KC_RESET    = 8'hff;

  // keyboard replies
  localparam logic [7:0] RPL_ACK   = 8'hfa;
  localparam logic [7:0] RPL_ECHO  = 8'hee;
  localparam logic [7:0] RPL_ERROR = 8'hfe;
  localparam logic [7:0] RPL_ID_HI = 8'h83;
  localparam logic [7:0] RPL_ID_LO = 8'hab;
  localparam logic [7:0] RPL_BAT   = 8'haa;

  // controller commands written to the command port
  localparam logic [7:0] CC_READ_CB  = 8'h20;
  localparam logic [7:0] CC_WRITE_CB = 8'h60;
  localparam logic [7:0] CC_WRITE_OP = 8'hd1;
  localparam logic [7:0] CC_PULSE_LO = 8'hf0;

  // output port values that drive the a20 gate
  localparam logic [7:0] A20_ON  = 8'hdf;
  localparam logic [7:0] A20_OFF = 8'hdd;

  // status and reset values
  localparam logic [7:0] STATUS_BASE  = 8'h1c;
  localparam logic [7:0] CMD_BYTE_DEF = 8'h01;
  localparam logic [7:0] SCAN_SET_DEF = 8'h01;
  localparam logic [7:0] RATE_DEF     = 8'h23;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;

  // parameter byte expected on the next data write
  typedef enum logic [6:0] {
    PW_IDLE    = 7'b0000001,
    PW_CMDBYTE = 7'b0000010,
    PW_OUTPORT = 7'b0000100,
    PW_LED     = 7'b0001000,
    PW_SCAN    = 7'b0010000,
    PW_RATE    = 7'b0100000,
    PW_KEYWAIT = 7'b1000000
  } pw_state_t;

  // reply queued for later data reads
  typedef enum logic [3:0] {
    PR_IDLE  = 4'b0001,
    PR_ID_HI = 4'b0010,
    PR_ID_LO = 4'b0100,
    PR_BAT   = 4'b1000
  } pr_state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_ready;
    pw_state_t  pw;
    pr_state_t  pr;
    logic [7:0] command_byte;
    logic [7:0] scan_set;
    logic [7:0] typematic_rate;
    logic       kbd_enabled;
  } kc_state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] port;
    logic [7:0] write_data;
  } kc_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] irq_pulses;
    logic       a20_write;
    logic       a20_level;
    logic       led_write;
    logic [2:0] led_bits;
    logic       irq_ack_seen;
  } kc_res_t;

  localparam kc_state_t STATE_RESET = '{
    out_byte:       BYTE_ZERO,
    out_ready:      1'b0,
    pw:             PW_IDLE,
    pr:             PR_IDLE,
    command_byte:   CMD_BYTE_DEF,
    scan_set:       SCAN_SET_DEF,
    typematic_rate: RATE_DEF,
    kbd_enabled:    1'b1
  };

endpackage

/* rtl/ps2kc_core.sv */
// Decode of one bus access: next controller state and the result of the access.
// Purely combinational; depends on ps2kc_pkg.
module ps2kc_core (
  input  ps2kc_pkg::kc_state_t st,
  input  ps2kc_pkg::kc_req_t   req,
  output ps2kc_pkg::kc_state_t st_next,
  output ps2kc_pkg::kc_res_t   res
);
  import ps2kc_pkg::*;

  logic [1:0] puts;
  logic       run_cmd;
  logic [7:0] v;

  assign v = req.write_data;

  always_comb begin
    st_next = st;
    res     = '0;
    puts    = 2'd0;
    run_cmd = 1'b0;

    if (req.op == OP_READ) begin
      if (req.port == PORT_DATA) begin
        // data read drains the buffer, then a queued reply moves in
        res.read_data     = st.out_byte;
        st_next.out_ready = 1'b0;
        case (st.pr)
          PR_ID_HI: begin
            st_next.out_byte  = RPL_ID_HI;
            st_next.out_ready = 1'b1;
            puts              = 2'd1;
            st_next.pr        = PR_ID_LO;
          end
          PR_ID_LO: begin
            st_next.out_byte  = RPL_ID_LO;
            st_next.out_ready = 1'b1;
            puts              = 2'd1;
            st_next.pr        = PR_IDLE;
          end
          PR_BAT: begin
            st_next.out_byte  = RPL_BAT;
            st_next.out_ready = 1'b1;
            puts              = 2'd1;
            st_next.pr        = PR_IDLE;
          end
          default: st_next.pr = PR_IDLE;
        endcase
      end else if (req.port == PORT_CMD) begin
        res.read_data = STATUS_BASE | {7'd0, st.out_ready};
      end
    end else if (req.port == PORT_DATA) begin
      // data write: parameter byte of a pending command, or a new command
      case (st.pw)
        PW_IDLE: run_cmd = 1'b1;
        PW_CMDBYTE: begin
          st_next.command_byte = v;
          st_next.pw           = PW_IDLE;
        end
        PW_OUTPORT: begin
          if (v == A20_ON) begin
            res.a20_write = 1'b1;
            res.a20_level = 1'b1;
          end else if (v == A20_OFF) begin
            res.a20_write = 1'b1;
          end
          st_next.out_ready = 1'b0;
          st_next.pw        = PW_IDLE;
        end
        PW_LED: begin
          res.led_write     = 1'b1;
          res.led_bits      = v[2:0];
          st_next.out_byte  = RPL_ACK;
          st_next.out_ready = 1'b1;
          puts              = 2'd1;
          st_next.pw        = PW_IDLE;
        end
        PW_SCAN: begin
          st_next.out_ready = 1'b1;
          if (v == BYTE_ZERO) begin
            // ack then the current set, two bytes through the buffer
            st_next.out_byte = st.scan_set;
            puts             = 2'd2;
          end else begin
            st_next.out_byte = RPL_ACK;
            st_next.scan_set = v;
            puts             = 2'd1;
          end
          st_next.pw = PW_IDLE;
        end
        PW_RATE: begin
          st_next.typematic_rate = v;
          st_next.out_byte       = RPL_ACK;
          st_next.out_ready      = 1'b1;
          puts                   = 2'd1;
          st_next.pw             = PW_IDLE;
        end
        default: begin
          // single-key wait restarts as a fresh command
          st_next.pw = PW_IDLE;
          run_cmd    = 1'b1;
        end
      endcase
    end else if (req.port == PORT_B) begin
      if (v[7]) begin
        st_next.out_ready = 1'b0;
        res.irq_ack_seen  = 1'b1;
      end
    end else if (req.port == PORT_CMD) begin
      // controller command
      if (v == CC_READ_CB) begin
        st_next.out_byte  = st.command_byte;
        st_next.out_ready = 1'b1;
        puts              = 2'd1;
      end else if (v == CC_WRITE_CB) begin
        st_next.pw = PW_CMDBYTE;
      end else if (v == CC_WRITE_OP) begin
        st_next.pw = PW_OUTPORT;
      end else if (v >= CC_PULSE_LO) begin
        st_next.pw        = PW_IDLE;
        st_next.out_ready = 1'b0;
      end
    end

    // keyboard command, every case places one byte in the buffer
    if (run_cmd) begin
      puts              = 2'd1;
      st_next.out_ready = 1'b1;
      st_next.out_byte  = RPL_ACK;
      case (v) inside
        KC_SET_LED:  st_next.pw = PW_LED;
        KC_ECHO:     st_next.out_byte = RPL_ECHO;
        KC_SCAN_SET: st_next.pw = PW_SCAN;
        KC_READ_ID:  st_next.pr = PR_ID_HI;
        KC_RATE:     st_next.pw = PW_RATE;
        KC_ENABLE:   st_next.kbd_enabled = 1'b1;
        KC_DIS_DEF, KC_DEFAULT: begin
          st_next.pr             = PR_IDLE;
          st_next.pw             = PW_IDLE;
          st_next.scan_set       = SCAN_SET_DEF;
          st_next.typematic_rate = RATE_DEF;
          st_next.kbd_enabled    = (v == KC_DEFAULT);
        end
        [KC_ALL_LO:KC_ALL_HI]: ;
        [KC_KEY_LO:KC_KEY_HI]: st_next.pw = PW_KEYWAIT;
        KC_RESEND:   st_next.out_byte = st.out_byte;
        KC_RESET:    st_next.pr = PR_BAT;
        default:     st_next.out_byte = RPL_ERROR;
      endcase
    end

    res.irq_pulses = st.command_byte[0] ? puts : 2'd0;
  end

endmodule

/* rtl/ps2_keyboard_controller_ports.sv */
// Top level of the ps/2 keyboard controller port block: stream handshake,
// controller state and result register. Depends on ps2kc_pkg and ps2kc_core.
//
// Each request is one byte access to the data port (0x60), port B (0x61) or the
// command/status port (0x64); each request gives exactly one result. A request is
// decoded and the controller state updated in the cycle it is accepted, and its
// result is held in the output register from the next cycle until taken. A new
// request is accepted every cycle while the output register is empty or being
// drained, so the block sustains one request per clock.
module ps2_keyboard_controller_ports (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // port[7:0], write_data[15:8]
  input  logic        s_tuser,   // op: 0 read, 1 write
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // read_data[7:0], irq_pulses[9:8], a20_write[10],
                                 // a20_level[11], led_write[12], led_bits[15:13],
                                 // irq_ack_seen[16], zero[23:17]
);
  import ps2kc_pkg::*;

  kc_state_t st;
  kc_state_t st_next;
  kc_req_t   req;
  kc_res_t   res_next;
  kc_res_t   res;
  logic      accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign req.op         = s_tuser;
  assign req.port       = s_tdata[7:0];
  assign req.write_data = s_tdata[15:8];

  ps2kc_core u_core (
    .st      (st),
    .req     (req),
    .st_next (st_next),
    .res     (res_next)
  );

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (accept) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_tdata = {7'd0, res.irq_ack_seen, res.led_bits, res.led_write,
                    res.a20_level, res.a20_write, res.irq_pulses, res.read_data};

endmodule

/* tb/ps2_keyboard_controller_ports_tb.sv */
// Self-checking testbench for ps2_keyboard_controller_ports: directed and random byte
// accesses with a built-in predictor of the 8042-style controller state.
// Depends on ps2kc_pkg and the ps2_keyboard_controller_ports RTL.
`timescale 1ns / 100ps

module ps2_keyboard_controller_ports_tb;
  import ps2kc_pkg::*;

  localparam int unsigned ITEMS_TOTAL = 1630;
  localparam int unsigned QUIET_LO    = 700;
  localparam int unsigned QUIET_HI    = 950;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 34;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // port[7:0], write_data[15:8]
  logic        s_tuser = 1'b0; // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // read_data[7:0], irq_pulses[9:8], a20_write[10],
                               // a20_level[11], led_write[12], led_bits[15:13],
                               // irq_ack_seen[16], zero[23:17]

  // predicted controller state
  logic [7:0]  kb_out_byte;
  logic        kb_out_ready;
  pw_state_t   kb_pw;
  pr_state_t   kb_pr;
  logic [7:0]  kb_cmd_byte;
  logic [7:0]  kb_scan_set;
  logic [7:0]  kb_rate;
  logic        kb_enabled;
  int unsigned irq_n;

  kc_res_t     awaited_res[$];
  int unsigned req_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned irq_res_cnt = 0;
  int unsigned a20_cnt = 0;
  int unsigned led_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_req = 1'b0;

  ps2_keyboard_controller_ports u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // a byte entering the output buffer raises irq1 when enabled
  function automatic void put_reply(input logic [7:0] b);
    kb_out_byte  = b;
    kb_out_ready = 1'b1;
    if (kb_cmd_byte[0]) irq_n++;
  endfunction

  function automatic void load_defaults();
    kb_pr        = STATE_RESET.pr;
    kb_pw        = STATE_RESET.pw;
    kb_scan_set  = STATE_RESET.scan_set;
    kb_rate      = STATE_RESET.typematic_rate;
    kb_enabled   = STATE_RESET.kbd_enabled;
    kb_out_byte  = STATE_RESET.out_byte;
    kb_out_ready = STATE_RESET.out_ready;
  endfunction

  function automatic void run_kbd_cmd(input logic [7:0] v);
    case (v)
      KC_SET_LED:  begin put_reply(RPL_ACK); kb_pw = PW_LED; end
      KC_ECHO:     put_reply(RPL_ECHO);
      KC_SCAN_SET: begin put_reply(RPL_ACK); kb_pw = PW_SCAN; end
      KC_READ_ID:  begin put_reply(RPL_ACK); kb_pr = PR_ID_HI; end
      KC_RATE:     begin put_reply(RPL_ACK); kb_pw = PW_RATE; end
      KC_ENABLE:   begin kb_enabled = 1'b1; put_reply(RPL_ACK); end
      KC_DIS_DEF:  begin load_defaults(); kb_enabled = 1'b0; put_reply(RPL_ACK); end
      KC_DEFAULT:  begin load_defaults(); put_reply(RPL_ACK); end
      KC_RESEND:   put_reply(kb_out_byte);
      KC_RESET:    begin put_reply(RPL_ACK); kb_pr = PR_BAT; end
      default: begin
        if (v inside {[KC_ALL_LO:KC_ALL_HI]}) begin
          put_reply(RPL_ACK);
        end else if (v inside {[KC_KEY_LO:KC_KEY_HI]}) begin
          put_reply(RPL_ACK);
          kb_pw = PW_KEYWAIT;
        end else begin
          put_reply(RPL_ERROR);
        end
      end
    endcase
  endfunction

  // result of one access, updating the predicted state
  function automatic kc_res_t predict_access(input logic op, input logic [7:0] port,
                                             input logic [7:0] v);
    kc_res_t r;
    r = '0;
    irq_n = 0;
    if (op == OP_READ) begin
      if (port == PORT_DATA) begin
        r.read_data  = kb_out_byte;
        kb_out_ready = 1'b0;
        case (kb_pr)
          PR_ID_HI: begin put_reply(RPL_ID_HI); kb_pr = PR_ID_LO; end
          PR_ID_LO: begin put_reply(RPL_ID_LO); kb_pr = PR_IDLE; end
          PR_BAT:   begin put_reply(RPL_BAT); kb_pr = PR_IDLE; end
          default:  kb_pr = PR_IDLE;
        endcase
      end else if (port == PORT_CMD) begin
        r.read_data = STATUS_BASE | {7'd0, kb_out_ready};
      end
    end else if (port == PORT_DATA) begin
      case (kb_pw)
        PW_IDLE: run_kbd_cmd(v);
        PW_CMDBYTE: begin
          kb_cmd_byte = v;
          kb_pw = PW_IDLE;
        end
        PW_OUTPORT: begin
          if (v == A20_ON) begin
            r.a20_write = 1'b1;
            r.a20_level = 1'b1;
          end else if (v == A20_OFF) begin
            r.a20_write = 1'b1;
          end
          kb_out_ready = 1'b0;
          kb_pw = PW_IDLE;
        end
        PW_LED: begin
          r.led_write = 1'b1;
          r.led_bits  = v[2:0];
          put_reply(RPL_ACK);
          kb_pw = PW_IDLE;
        end
        PW_SCAN: begin
          put_reply(RPL_ACK);
          if (v == BYTE_ZERO) put_reply(kb_scan_set);
          else kb_scan_set = v;
          kb_pw = PW_IDLE;
        end
        PW_RATE: begin
          kb_rate = v;
          put_reply(RPL_ACK);
          kb_pw = PW_IDLE;
        end
        default: begin
          kb_pw = PW_IDLE;
          run_kbd_cmd(v);
        end
      endcase
    end else if (port == PORT_B) begin
      if (v[7]) begin
        kb_out_ready   = 1'b0;
        r.irq_ack_seen = 1'b1;
      end
    end else if (port == PORT_CMD) begin
      if (v == CC_READ_CB) begin
        put_reply(kb_cmd_byte);
      end else if (v == CC_WRITE_CB) begin
        kb_pw = PW_CMDBYTE;
      end else if (v == CC_WRITE_OP) begin
        kb_pw = PW_OUTPORT;
      end else if (v >= CC_PULSE_LO) begin
        kb_pw = PW_IDLE;
        kb_out_ready = 1'b0;
      end
    end
    r.irq_pulses = irq_n[1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- request side

  // offer one request, with random gaps, and record its expected result
  task automatic send_req(input logic op, input logic [7:0] port, input logic [7:0] wd);
    while (tx_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {wd, port};
    do @(posedge clk); while (!s_tready);
    awaited_res.push_back(predict_access(op, port, wd));
    req_cnt++;
  endtask

  task automatic wr(input logic [7:0] port, input logic [7:0] wd);
    send_req(OP_WRITE, port, wd);
  endtask

  task automatic rd(input logic [7:0] port);
    send_req(OP_READ, port, 8'($urandom_range(0, 255)));
  endtask

  // stop offering and let every outstanding result come back
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (awaited_res.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- result side

  // result acceptor: random stalls, plus a long hold-off when requested
  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(rx_gaps && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin : res_check
    kc_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_res.size() == 0) begin
        $error("unexpected result 0x%06h with no request outstanding", m_tdata);
        fail_cnt++;
      end else begin
        want = awaited_res.pop_front();
        res_cnt++;
        if (want.irq_pulses != 0) irq_res_cnt++;
        if (want.a20_write) a20_cnt++;
        if (want.led_write) led_cnt++;
        check_field("read_data", 32'(want.read_data), 32'(m_tdata[7:0]));
        check_field("irq_pulses", 32'(want.irq_pulses), 32'(m_tdata[9:8]));
        check_field("a20_write", 32'(want.a20_write), 32'(m_tdata[10]));
        check_field("a20_level", 32'(want.a20_level), 32'(m_tdata[11]));
        check_field("led_write", 32'(want.led_write), 32'(m_tdata[12]));
        check_field("led_bits", 32'(want.led_bits), 32'(m_tdata[15:13]));
        check_field("irq_ack_seen", 32'(want.irq_ack_seen), 32'(m_tdata[16]));
        check_field("pad", 0, 32'(m_tdata[23:17]));
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("ps2_keyboard_controller_ports_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // status, data, port b and unknown-port reads straight after reset
  task automatic test_reset_reads();
    rd(PORT_CMD);
    rd(PORT_DATA);
    rd(PORT_B);
    rd(8'h00);
    rd(8'hff);
  endtask

  // keyboard commands and their queued replies
  task automatic test_kbd_commands();
    wr(PORT_DATA, KC_RESET);
    rd(PORT_DATA);
    rd(PORT_DATA);
    wr(PORT_DATA, KC_READ_ID);
    rd(PORT_DATA);
    rd(PORT_DATA);
    rd(PORT_DATA);
    wr(PORT_DATA, KC_SET_LED);
    wr(PORT_DATA, 8'hff);
    // scan set query gives two bytes, two irqs
    wr(PORT_DATA, KC_SCAN_SET);
    wr(PORT_DATA, BYTE_ZERO);
    // single-key wait falls through to a fresh command
    wr(PORT_DATA, KC_KEY_LO);
    wr(PORT_DATA, KC_ECHO);
    wr(PORT_DATA, 8'h00);
    wr(PORT_DATA, KC_RESEND);
  endtask

  // command port: command byte, a20 drive, pulse, port b ack
  task automatic test_ctrl_commands();
    wr(PORT_CMD, CC_WRITE_CB);
    wr(PORT_DATA, BYTE_ZERO);
    wr(PORT_DATA, KC_ECHO);
    wr(PORT_CMD, CC_READ_CB);
    rd(PORT_CMD);
    wr(PORT_CMD, CC_WRITE_OP);
    wr(PORT_DATA, A20_ON);
    wr(PORT_B, 8'h80);
    wr(PORT_CMD, 8'hff);
    wr(PORT_CMD, CC_WRITE_CB);
    wr(PORT_DATA, CMD_BYTE_DEF);
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (24) begin
      if ($urandom_range(0, 1)) wr(PORT_DATA, KC_ECHO);
      else rd(PORT_DATA);
    end
    wait_results_done();
  endtask

  // mostly well-formed command sequences with random content, plus noise
  task automatic test_random_traffic();
    logic [7:0]  cmd;
    logic [7:0]  prm;
    int unsigned next_pause;
    next_pause = req_cnt + 450;
    while (req_cnt < ITEMS_TOTAL) begin
      tx_gaps = !(req_cnt inside {[QUIET_LO:QUIET_HI]});
      rx_gaps = tx_gaps;
      if (req_cnt >= next_pause) begin
        wait_results_done();
        next_pause = req_cnt + 450;
      end
      case ($urandom_range(0, 99)) inside
        [0:31]: begin
          // keyboard command, its parameter where it takes one, then up to three data reads
          case ($urandom_range(0, 13))
            0:  cmd = KC_SET_LED;
            1:  cmd = KC_ECHO;
            2:  cmd = KC_SCAN_SET;
            3:  cmd = KC_READ_ID;
            4:  cmd = KC_RATE;
            5:  cmd = KC_ENABLE;
            6:  cmd = KC_DIS_DEF;
            7:  cmd = KC_DEFAULT;
            8:  cmd = KC_RESEND;
            9:  cmd = KC_RESET;
            10: cmd = 8'($urandom_range(KC_ALL_LO, KC_ALL_HI));
            11: cmd = 8'($urandom_range(KC_KEY_LO, KC_KEY_HI));
            default: cmd = 8'($urandom_range(0, 255));
          endcase
          wr(PORT_DATA, cmd);
          if (cmd == KC_SET_LED || cmd == KC_SCAN_SET || cmd == KC_RATE ||
              cmd inside {[KC_KEY_LO:KC_KEY_HI]}) begin
            prm = 8'($urandom_range(0, 255));
            if (cmd == KC_SCAN_SET && $urandom_range(0, 2) == 0) prm = BYTE_ZERO;
            wr(PORT_DATA, prm);
          end
          repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 3) == 0) rd(PORT_CMD);
            rd(PORT_DATA);
          end
        end
        [32:47]: begin
          // controller command on the command port
          case ($urandom_range(0, 4))
            0: begin
              wr(PORT_CMD, CC_READ_CB);
              rd(PORT_DATA);
            end
            1: begin
              wr(PORT_CMD, CC_WRITE_CB);
              prm = 8'($urandom_range(0, 255));
              prm[0] = ($urandom_range(0, 9) != 0);
              wr(PORT_DATA, prm);
            end
            2: begin
              wr(PORT_CMD, CC_WRITE_OP);
              case ($urandom_range(0, 2))
                0: wr(PORT_DATA, A20_ON);
                1: wr(PORT_DATA, A20_OFF);
                default: wr(PORT_DATA, 8'($urandom_range(0, 255)));
              endcase
            end
            3: wr(PORT_CMD, 8'($urandom_range(CC_PULSE_LO, 255)));
            default: wr(PORT_CMD, 8'($urandom_range(0, 255)));
          endcase
        end
        [48:71]: begin
          if ($urandom_range(0, 2) == 0) rd(PORT_CMD);
          else rd(PORT_DATA);
        end
        [72:81]: begin
          if ($urandom_range(0, 3) == 0) rd(PORT_B);
          else wr(PORT_B, 8'($urandom_range(0, 255)));
        end
        default: begin
          // noise: any kind, any port, any byte
          case ($urandom_range(0, 3))
            0: prm = PORT_DATA;
            1: prm = PORT_B;
            2: prm = PORT_CMD;
            default: prm = 8'($urandom_range(0, 255));
          endcase
          send_req(1'($urandom_range(0, 1)), prm, 8'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    kb_cmd_byte = STATE_RESET.command_byte;
    load_defaults();
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_reads();
    test_kbd_commands();
    test_ctrl_commands();
    test_backpressure();
    test_random_traffic();

    wait_results_done();
    repeat (5) @(posedge clk);
    $display("sent %0d requests, checked %0d results (%0d with irq, %0d a20 drives,",
             req_cnt, res_cnt, irq_res_cnt, a20_cnt);
    $display("%0d led writes), with long receiver hold-off and idle pauses", led_cnt);
    if (fail_cnt == 0 && awaited_res.size() == 0) begin
      $display("ps2_keyboard_controller_ports_tb OK");
    end else begin
      $display("ps2_keyboard_controller_ports_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ps2kc_pkg.sv
rtl/ps2kc_core.sv
rtl/ps2_keyboard_controller_ports.sv
tb/ps2_keyboard_controller_ports_tb.sv
